FILE: sv/gdr_pkg.sv
// shared types and constants of the grid dda column ray caster
package gdr_pkg;

    localparam int MAP_BITS   = 6;
    localparam int ADDR_BITS  = 2 * MAP_BITS;
    localparam int MAP_DEPTH  = 1 << ADDR_BITS;
    localparam int FRAC       = 16;
    localparam int COL_BITS   = 10;
    localparam int DIST_BITS  = 24;
    localparam int SIDE_BITS  = 51;
    localparam int DELTA_BITS = 43;
    localparam int DIV_BITS   = 33;
    localparam int DSR_BITS   = 24;
    localparam int DIR_BITS   = 21;
    localparam int CNT_BITS   = 8;

    localparam logic [MAP_BITS-1:0]   MAP_LAST   = '1;
    localparam logic [CNT_BITS-1:0]   WALK_LIMIT = 8'd130;
    localparam logic [11:0]           SCREEN_W   = 12'd640;
    localparam logic [15:0]           VIEW_RECIP = 16'd52429;
    localparam logic [14:0]           HALF_H     = 15'd240;
    localparam logic [8:0]            LAST_ROW   = 9'd479;
    localparam logic [DIV_BITS-1:0]   RECIP_NUM  = 33'h1_0000_0000;
    localparam logic [DIV_BITS-1:0]   LINE_NUM   = 33'd31457280;
    localparam logic [DELTA_BITS-1:0] HUGE_DIST  = 43'h400_0000_0000;
    localparam logic [DIST_BITS-1:0]  PERP_MAX   = '1;
    localparam logic [15:0]           LINE_MAX   = '1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    localparam logic [2:0] REG_PLAYER_X = 3'd0;
    localparam logic [2:0] REG_PLAYER_Y = 3'd1;
    localparam logic [2:0] REG_DIR_X    = 3'd2;
    localparam logic [2:0] REG_DIR_Y    = 3'd3;
    localparam logic [2:0] REG_PLANE_X  = 3'd4;
    localparam logic [2:0] REG_PLANE_Y  = 3'd5;

    typedef struct packed {
        logic                is_cast;
        logic [MAP_BITS-1:0] cell_col;
        logic [MAP_BITS-1:0] cell_row;
        logic                cell_is_wall;
        logic [COL_BITS-1:0] screen_column;
    } t_cmd;

    typedef struct packed {
        logic [21:0]        player_x;
        logic [21:0]        player_y;
        logic signed [17:0] view_dir_x;
        logic signed [17:0] view_dir_y;
        logic signed [17:0] camera_plane_x;
        logic signed [17:0] camera_plane_y;
    } t_cfg;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef struct packed {
        logic [COL_BITS-1:0]  column_out;
        logic                 hit_side;
        logic [MAP_BITS-1:0]  hit_col;
        logic [MAP_BITS-1:0]  hit_row;
        logic [DIST_BITS-1:0] perp_distance;
        logic [15:0]          wall_fraction;
        logic [15:0]          line_height;
        logic [8:0]           draw_start;
        logic [8:0]           draw_end;
        logic                 left_map;
    } t_result;

endpackage

FILE: sv/grid_dda_column_raycaster.sv
// top level of the grid dda column ray caster: config registers and the two halves
//
// usage
//   slave stream: tuser = action (0 writes one map cell, 1 casts one column),
//   tdata carries the cell indexes, wall bit and screen column. a write is applied
//   in the back end and gives no result transaction.
//   master stream: one result transaction per cast, holding side, hit cell,
//   perpendicular distance, wall fraction, line height and clamped draw rows.
//   config port: i_cfg_we with i_cfg_index and i_cfg_data, written only while idle
//   by the user; the block itself does not enforce it.
// cast sequence
//   a cast runs three divides on a shared bit-serial divider (x and y reciprocals,
//   line height), states for pop, view, ray, side distances, distance, wall product
//   and result load, and the dda walk (S_STEP then S_CHK, S_STEP alone to leave the grid).
//   a two-entry command queue lets the front take new transactions while a cast runs.
// reset
//   registers take their defaults; the 4096-cell map is cleared one cell per cycle,
//   and s_axis_tready stays low while it clears.
// stall
//   a finished result waits in the output register; the back end holds in its last
//   state until the register frees, while the queue keeps filling.
module grid_dda_column_raycaster (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // slave stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // cell_col, cell_row, cell_is_wall, screen_column, zero pad
    input  logic [23:0]   s_axis_tdata,
    // action
    input  logic          s_axis_tuser,
    // master stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // column_out, hit_side, hit_col, hit_row, perp_distance, wall_fraction,
    // line_height, draw_start, draw_end, left_map, zero pad
    output logic [103:0]  m_axis_tdata,
    // configuration writes
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [21:0]   i_cfg_data
);

    gdr_pkg::t_cfg       r_cfg;
    gdr_pkg::t_back_stat stat;
    gdr_pkg::t_cmd       q_cmd;
    gdr_pkg::t_result    res;
    logic                q_valid;
    logic                q_pop;

    // register file, reset to player at origin, looking along +x
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.player_x       <= '0;
            r_cfg.player_y       <= '0;
            r_cfg.view_dir_x     <= 18'sd65536;
            r_cfg.view_dir_y     <= '0;
            r_cfg.camera_plane_x <= '0;
            r_cfg.camera_plane_y <= 18'sd43254;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gdr_pkg::REG_PLAYER_X: r_cfg.player_x       <= i_cfg_data;
                gdr_pkg::REG_PLAYER_Y: r_cfg.player_y       <= i_cfg_data;
                gdr_pkg::REG_DIR_X:    r_cfg.view_dir_x     <= $signed(i_cfg_data[17:0]);
                gdr_pkg::REG_DIR_Y:    r_cfg.view_dir_y     <= $signed(i_cfg_data[17:0]);
                gdr_pkg::REG_PLANE_X:  r_cfg.camera_plane_x <= $signed(i_cfg_data[17:0]);
                gdr_pkg::REG_PLANE_Y:  r_cfg.camera_plane_y <= $signed(i_cfg_data[17:0]);
                default: begin
                end
            endcase
        end
    end

    gdr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_stat        (stat),
        .o_q_valid     (q_valid),
        .o_q_cmd       (q_cmd),
        .i_q_pop       (q_pop)
    );

    gdr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_stat      (stat),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    // pack result fields, first field in the low bits
    assign m_axis_tdata = {6'b0, res.left_map, res.draw_end, res.draw_start,
                           res.line_height, res.wall_fraction, res.perp_distance,
                           res.hit_row, res.hit_col, res.hit_side, res.column_out};

endmodule

FILE: sv/gdr_front.sv
// input side: takes stream transactions, classifies them, queues commands
module gdr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,
    input  logic                s_axis_tuser,
    input  gdr_pkg::t_back_stat i_stat,
    output logic                o_q_valid,
    output gdr_pkg::t_cmd       o_q_cmd,
    input  logic                i_q_pop
);

    gdr_pkg::t_cmd r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    gdr_pkg::t_cmd n_cmd;
    logic          push;
    logic          pop;

    assign s_axis_tready = (r_count != 2'd2) && !i_stat.clearing;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = i_q_pop && (r_count != 2'd0);
    assign o_q_valid     = (r_count != 2'd0);
    assign o_q_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_cmd.is_cast       = (s_axis_tuser == gdr_pkg::ACT_CAST);
        n_cmd.cell_col      = s_axis_tdata[5:0];
        n_cmd.cell_row      = s_axis_tdata[11:6];
        n_cmd.cell_is_wall  = s_axis_tdata[12];
        n_cmd.screen_column = s_axis_tdata[22:13];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: sv/gdr_div.sv
// restoring divider, one quotient bit per cycle
module gdr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [gdr_pkg::DIV_BITS-1:0] i_dividend,
    input  logic [gdr_pkg::DSR_BITS-1:0] i_divisor,
    output logic                         o_done,
    output logic [gdr_pkg::DIV_BITS-1:0] o_quot
);

    logic [gdr_pkg::DIV_BITS-1:0] r_dvd;
    logic [gdr_pkg::DSR_BITS-1:0] r_dsr;
    logic [gdr_pkg::DSR_BITS:0]   r_rem;
    logic [5:0]                   r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [gdr_pkg::DSR_BITS:0]   shifted;
    logic                         fits;

    assign shifted = {r_rem[gdr_pkg::DSR_BITS-1:0], r_dvd[gdr_pkg::DIV_BITS-1]};
    assign fits    = shifted >= {1'b0, r_dsr};
    assign o_done  = r_done;
    assign o_quot  = r_dvd;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? shifted - {1'b0, r_dsr} : shifted;
            r_dvd <= {r_dvd[gdr_pkg::DIV_BITS-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(gdr_pkg::DIV_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: sv/gdr_back.sv
// execution side: map store, ray setup, dda walk and result register
module gdr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gdr_pkg::t_cfg       i_cfg,
    input  logic                i_q_valid,
    input  gdr_pkg::t_cmd       i_q_cmd,
    output logic                o_q_pop,
    output gdr_pkg::t_back_stat o_stat,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output gdr_pkg::t_result    o_res
);

    typedef enum logic [19:0] {
        S_CLEAR  = 20'b0000_0000_0000_0000_0001,
        S_IDLE   = 20'b0000_0000_0000_0000_0010,
        S_VIEW_M = 20'b0000_0000_0000_0000_0100,
        S_VIEW_C = 20'b0000_0000_0000_0000_1000,
        S_DX_M   = 20'b0000_0000_0000_0001_0000,
        S_DY_M   = 20'b0000_0000_0000_0010_0000,
        S_DIR    = 20'b0000_0000_0000_0100_0000,
        S_RCP_X  = 20'b0000_0000_0000_1000_0000,
        S_RCP_Y  = 20'b0000_0000_0001_0000_0000,
        S_SX_HI  = 20'b0000_0000_0010_0000_0000,
        S_SX_LO  = 20'b0000_0000_0100_0000_0000,
        S_SY_HI  = 20'b0000_0000_1000_0000_0000,
        S_SY_LO  = 20'b0000_0001_0000_0000_0000,
        S_SY_FIN = 20'b0000_0010_0000_0000_0000,
        S_STEP   = 20'b0000_0100_0000_0000_0000,
        S_CHK    = 20'b0000_1000_0000_0000_0000,
        S_DIST   = 20'b0001_0000_0000_0000_0000,
        S_WALL_M = 20'b0010_0000_0000_0000_0000,
        S_LINE   = 20'b0100_0000_0000_0000_0000,
        S_OUT    = 20'b1000_0000_0000_0000_0000
    } t_state;

    localparam int AB = gdr_pkg::ADDR_BITS;
    localparam int MB = gdr_pkg::MAP_BITS;
    localparam int DIR_BITS = gdr_pkg::DIR_BITS;

    t_state n_state;
    t_state r_state;

    logic r_map [gdr_pkg::MAP_DEPTH];
    logic r_rd;

    logic [gdr_pkg::COL_BITS-1:0]   r_col;
    logic                           r_neg;
    logic [19:0]                    r_a;
    logic signed [18:0]             r_view;
    logic signed [gdr_pkg::DIR_BITS-1:0] r_dir_x;
    logic signed [gdr_pkg::DIR_BITS-1:0] r_dir_y;
    logic [gdr_pkg::DELTA_BITS-1:0] r_dx;
    logic [gdr_pkg::DELTA_BITS-1:0] r_dy;
    logic [34:0]                    r_acc;
    logic [gdr_pkg::SIDE_BITS-1:0]  r_sx;
    logic [gdr_pkg::SIDE_BITS-1:0]  r_sy;
    logic [MB-1:0]                  r_mx;
    logic [MB-1:0]                  r_my;
    logic                           r_side;
    logic                           r_left;
    logic [gdr_pkg::CNT_BITS-1:0]   r_cnt;
    logic [gdr_pkg::DIST_BITS-1:0]  r_dist;
    logic [15:0]                    r_wf;
    logic [15:0]                    r_line;
    logic [AB-1:0]                  r_clr;
    logic signed [46:0]             r_prod;
    logic                           r_ovalid;
    gdr_pkg::t_result               r_res;

    logic signed [24:0] m_a;
    logic signed [21:0] m_b;
    logic [16:0]        frac_x;
    logic [16:0]        frac_y;

    logic                         div_start;
    logic [gdr_pkg::DIV_BITS-1:0] div_num;
    logic [gdr_pkg::DSR_BITS-1:0] div_dsr;
    logic                         div_done;
    logic [gdr_pkg::DIV_BITS-1:0] div_quot;

    logic [11:0]                  num;
    logic [10:0]                  num_mag;
    logic [19:0]                  q0;
    logic [22:0]                  q0_x5;
    logic [17:0]                  q_view;
    logic [gdr_pkg::DIR_BITS-1:0] abs_x;
    logic [gdr_pkg::DIR_BITS-1:0] abs_y;
    logic                         take_x;
    logic                         x_out;
    logic                         y_out;
    logic [MB-1:0]                nx;
    logic [MB-1:0]                ny;
    logic [AB-1:0]                rd_addr;
    logic [gdr_pkg::SIDE_BITS-1:0] dist_full;
    logic                         map_we;
    logic [AB-1:0]                map_addr;
    logic                         map_din;
    logic                         res_load;
    logic [14:0]                  half;

    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_q_pop         = (r_state == S_IDLE) && i_q_valid;
    assign o_res_valid     = r_ovalid;
    assign o_res           = r_res;
    assign res_load        = (r_state == S_OUT) && (!r_ovalid || i_res_ready);

    // camera coordinate numerator (2*col - width), split into sign and magnitude
    assign num     = {1'b0, i_q_cmd.screen_column, 1'b0} - gdr_pkg::SCREEN_W;
    assign num_mag = num[11] ? 11'(-num) : num[10:0];

    // reciprocal multiply by 1/5 overshoots by at most one
    assign q0     = r_prod[37:18];
    assign q0_x5  = {1'b0, q0, 2'b00} + {3'b000, q0};
    assign q_view = (q0_x5 > {3'b000, r_a}) ? 18'(q0 - 20'd1) : q0[17:0];

    assign abs_x = r_dir_x[gdr_pkg::DIR_BITS-1] ? DIR_BITS'(-r_dir_x) : r_dir_x;
    assign abs_y = r_dir_y[gdr_pkg::DIR_BITS-1] ? DIR_BITS'(-r_dir_y) : r_dir_y;

    assign frac_x = r_dir_x[DIR_BITS-1] ? {1'b0, i_cfg.player_x[15:0]}
                                        : 17'h10000 - {1'b0, i_cfg.player_x[15:0]};
    assign frac_y = r_dir_y[DIR_BITS-1] ? {1'b0, i_cfg.player_y[15:0]}
                                        : 17'h10000 - {1'b0, i_cfg.player_y[15:0]};

    // next dda step
    assign take_x  = r_sx < r_sy;
    assign nx      = r_dir_x[DIR_BITS-1] ? r_mx - 6'd1 : r_mx + 6'd1;
    assign ny      = r_dir_y[DIR_BITS-1] ? r_my - 6'd1 : r_my + 6'd1;
    assign x_out   = r_dir_x[DIR_BITS-1] ? (r_mx == '0) : (r_mx == gdr_pkg::MAP_LAST);
    assign y_out   = r_dir_y[DIR_BITS-1] ? (r_my == '0) : (r_my == gdr_pkg::MAP_LAST);
    assign rd_addr = take_x ? {r_my, nx} : {ny, r_mx};

    assign dist_full = r_side ? r_sy - gdr_pkg::SIDE_BITS'(r_dy)
                              : r_sx - gdr_pkg::SIDE_BITS'(r_dx);
    assign half      = r_line[15:1];

    // shared multiplier operands
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_VIEW_M: begin
                m_a = $signed({5'b0, r_a});
                m_b = $signed({6'b0, gdr_pkg::VIEW_RECIP});
            end
            S_DX_M: begin
                m_a = 25'(i_cfg.camera_plane_x);
                m_b = 22'(r_view);
            end
            S_DY_M: begin
                m_a = 25'(i_cfg.camera_plane_y);
                m_b = 22'(r_view);
            end
            S_SX_HI: begin
                m_a = $signed({8'b0, frac_x});
                m_b = $signed({5'b0, r_dx[32:16]});
            end
            S_SX_LO: begin
                m_a = $signed({8'b0, frac_x});
                m_b = $signed({6'b0, r_dx[15:0]});
            end
            S_SY_HI: begin
                m_a = $signed({8'b0, frac_y});
                m_b = $signed({5'b0, r_dy[32:16]});
            end
            S_SY_LO: begin
                m_a = $signed({8'b0, frac_y});
                m_b = $signed({6'b0, r_dy[15:0]});
            end
            // wall product held steady while the line height divide runs
            S_WALL_M, S_LINE: begin
                m_a = $signed({1'b0, r_dist});
                m_b = r_side ? 22'(r_dir_x) : 22'(r_dir_y);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // divider requests: x and y reciprocals, then the line height
    always_comb begin
        div_start = 1'b0;
        div_num   = gdr_pkg::RECIP_NUM;
        div_dsr   = '0;
        case (r_state)
            S_DIR: begin
                div_start = 1'b1;
                div_dsr   = gdr_pkg::DSR_BITS'(abs_x);
            end
            S_RCP_X: begin
                div_start = div_done;
                div_dsr   = gdr_pkg::DSR_BITS'(abs_y);
            end
            S_WALL_M: begin
                div_start = 1'b1;
                div_num   = gdr_pkg::LINE_NUM;
                div_dsr   = r_dist;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    gdr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        map_we   = 1'b0;
        map_addr = r_clr;
        map_din  = 1'b0;
        if (r_state == S_CLEAR) begin
            map_we = 1'b1;
        end else if ((r_state == S_IDLE) && i_q_valid && !i_q_cmd.is_cast) begin
            map_we   = 1'b1;
            map_addr = {i_q_cmd.cell_row, i_q_cmd.cell_col};
            map_din  = i_q_cmd.cell_is_wall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_addr] <= map_din;
        end
        r_rd <= r_map[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_clr == '1) n_state = S_IDLE;
            S_IDLE:   if (i_q_valid && i_q_cmd.is_cast) n_state = S_VIEW_M;
            S_VIEW_M: n_state = S_VIEW_C;
            S_VIEW_C: n_state = S_DX_M;
            S_DX_M:   n_state = S_DY_M;
            S_DY_M:   n_state = S_DIR;
            S_DIR:    n_state = S_RCP_X;
            S_RCP_X:  if (div_done) n_state = S_RCP_Y;
            S_RCP_Y:  if (div_done) n_state = S_SX_HI;
            S_SX_HI:  n_state = S_SX_LO;
            S_SX_LO:  n_state = S_SY_HI;
            S_SY_HI:  n_state = S_SY_LO;
            S_SY_LO:  n_state = S_SY_FIN;
            S_SY_FIN: n_state = S_STEP;
            S_STEP: begin
                if ((r_cnt == gdr_pkg::WALK_LIMIT) || (take_x ? x_out : y_out)) begin
                    n_state = S_DIST;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK:    n_state = r_rd ? S_DIST : S_STEP;
            S_DIST:   n_state = S_WALL_M;
            S_WALL_M: n_state = S_LINE;
            S_LINE:   if (div_done) n_state = S_OUT;
            S_OUT:    if (res_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        case (r_state)
            S_IDLE: begin
                r_col  <= i_q_cmd.screen_column;
                r_neg  <= num[11];
                r_a    <= {num_mag, 9'b0};
                r_mx   <= i_cfg.player_x[21:16];
                r_my   <= i_cfg.player_y[21:16];
                r_left <= 1'b0;
                r_side <= 1'b0;
                r_cnt  <= '0;
            end
            S_VIEW_C: begin
                r_view <= r_neg ? -$signed({1'b0, q_view}) : $signed({1'b0, q_view});
            end
            S_DY_M: begin
                r_dir_x <= DIR_BITS'(i_cfg.view_dir_x) + $signed(r_prod[36:16]);
            end
            S_DIR: begin
                r_dir_y <= DIR_BITS'(i_cfg.view_dir_y) + $signed(r_prod[36:16]);
            end
            S_RCP_X: begin
                if (div_done) begin
                    r_dx <= (r_dir_x == '0) ? gdr_pkg::HUGE_DIST
                                            : gdr_pkg::DELTA_BITS'(div_quot);
                end
            end
            S_RCP_Y: begin
                if (div_done) begin
                    r_dy <= (r_dir_y == '0) ? gdr_pkg::HUGE_DIST
                                            : gdr_pkg::DELTA_BITS'(div_quot);
                end
            end
            S_SX_LO: r_acc <= r_prod[34:0];
            S_SY_HI: begin
                r_sx <= (r_dir_x == '0) ? gdr_pkg::SIDE_BITS'(gdr_pkg::HUGE_DIST)
                        : gdr_pkg::SIDE_BITS'(r_acc) + gdr_pkg::SIDE_BITS'(r_prod[32:16]);
            end
            S_SY_LO: r_acc <= r_prod[34:0];
            S_SY_FIN: begin
                r_sy <= (r_dir_y == '0) ? gdr_pkg::SIDE_BITS'(gdr_pkg::HUGE_DIST)
                        : gdr_pkg::SIDE_BITS'(r_acc) + gdr_pkg::SIDE_BITS'(r_prod[32:16]);
            end
            S_STEP: begin
                if (r_cnt == gdr_pkg::WALK_LIMIT) begin
                    r_left <= 1'b1;
                end else begin
                    r_cnt  <= r_cnt + 8'd1;
                    r_side <= !take_x;
                    if (take_x) begin
                        r_sx <= r_sx + gdr_pkg::SIDE_BITS'(r_dx);
                        if (x_out) r_left <= 1'b1;
                        else       r_mx   <= nx;
                    end else begin
                        r_sy <= r_sy + gdr_pkg::SIDE_BITS'(r_dy);
                        if (y_out) r_left <= 1'b1;
                        else       r_my   <= ny;
                    end
                end
            end
            S_DIST: begin
                r_dist <= (dist_full > gdr_pkg::SIDE_BITS'(gdr_pkg::PERP_MAX))
                          ? gdr_pkg::PERP_MAX : dist_full[gdr_pkg::DIST_BITS-1:0];
            end
            S_LINE: begin
                r_wf <= (r_side ? i_cfg.player_x[15:0] : i_cfg.player_y[15:0])
                        + r_prod[31:16];
                if (div_done) begin
                    r_line <= ((r_dist == '0) || (div_quot[32:16] != '0))
                              ? gdr_pkg::LINE_MAX : div_quot[15:0];
                end
            end
            default: begin
            end
        endcase
        if (res_load) begin
            r_res.column_out    <= r_col;
            r_res.hit_side      <= r_side;
            r_res.hit_col       <= r_mx;
            r_res.hit_row       <= r_my;
            r_res.perp_distance <= r_dist;
            r_res.wall_fraction <= r_wf;
            r_res.line_height   <= r_line;
            r_res.draw_start    <= (half >= gdr_pkg::HALF_H) ? 9'd0
                                   : 9'(gdr_pkg::HALF_H - half);
            r_res.draw_end      <= (half >= gdr_pkg::HALF_H) ? gdr_pkg::LAST_ROW
                                   : 9'(gdr_pkg::HALF_H + half);
            r_res.left_map      <= r_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (res_load)         r_ovalid <= 1'b1;
            else if (i_res_ready) r_ovalid <= 1'b0;
        end
    end

endmodule
